[hw/rtl/vtu_pkg.sv]
// vtu_pkg: shared types, register map codes and arithmetic helpers
// for the vertex transform unit; depends on nothing else
package vtu_pkg;

  localparam int unsigned AddrWidth = 5;
  localparam int unsigned DataWidth = 32;

  // transform modes
  localparam logic [2:0] MODE_TRANSLATE = 3'd0;
  localparam logic [2:0] MODE_SCALE     = 3'd1;
  localparam logic [2:0] MODE_ORIENT    = 3'd2;
  localparam logic [2:0] MODE_MIRROR    = 3'd3;
  localparam logic [2:0] MODE_HILLSKEW  = 3'd4;

  // register indexes (word address)
  localparam logic [2:0] REG_MODE  = 3'd0;
  localparam logic [2:0] REG_ARG_X = 3'd1;
  localparam logic [2:0] REG_ARG_Y = 3'd2;
  localparam logic [2:0] REG_ARG_Z = 3'd3;
  localparam logic [2:0] REG_H_SW  = 3'd4;
  localparam logic [2:0] REG_H_SE  = 3'd5;
  localparam logic [2:0] REG_H_NE  = 3'd6;
  localparam logic [2:0] REG_H_NW  = 3'd7;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [15:0] arg_x;
    logic signed [15:0] arg_y;
    logic signed [15:0] arg_z;
    logic signed [15:0] h_sw;
    logic signed [15:0] h_se;
    logic signed [15:0] h_ne;
    logic signed [15:0] h_nw;
  } vtu_cfg_t;

  // signed division by 128 truncating toward zero
  function automatic logic signed [47:0] div128(input logic signed [47:0] v);
    logic signed [47:0] bias;
    bias = v[47] ? 48'sd127 : 48'sd0;
    return (v + bias) >>> 7;
  endfunction

  // clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
    logic signed [31:0] r;
    if (v > 41'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -41'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[hw/rtl/vertex_transform_unit.sv]
// vertex_transform_unit: register file and vertex pipeline.
// A vertex taken by start comes out with a strobe on done once it has passed the stages of vtu_pipe.
// Throughput: one vertex per cycle, each of the five register stages of vtu_pipe takes
// a new vertex every cycle; busy stays low, and results cannot be held off by the receiver.
// Reset (synchronous, rst high) clears the configuration registers and empties the pipeline.
// Depends on vtu_pkg and vtu_pipe.
module vertex_transform_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [15:0]                 pos_x,
  input  logic signed [15:0]                 pos_y,
  input  logic signed [15:0]                 pos_z,
  input  logic                               last_vertex,
  output logic                               done,
  output logic signed [31:0]                 out_x,
  output logic signed [31:0]                 out_y,
  output logic signed [31:0]                 out_z,
  output logic                               out_last,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [vtu_pkg::AddrWidth-1:0]      paddr,
  input  logic [vtu_pkg::DataWidth-1:0]      pwdata,
  output logic [vtu_pkg::DataWidth-1:0]      prdata,
  output logic                               pready
);
  import vtu_pkg::*;

  vtu_cfg_t   cfg;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[AddrWidth-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MODE:  cfg.mode  <= pwdata[2:0];
        REG_ARG_X: cfg.arg_x <= pwdata[15:0];
        REG_ARG_Y: cfg.arg_y <= pwdata[15:0];
        REG_ARG_Z: cfg.arg_z <= pwdata[15:0];
        REG_H_SW:  cfg.h_sw  <= pwdata[15:0];
        REG_H_SE:  cfg.h_se  <= pwdata[15:0];
        REG_H_NE:  cfg.h_ne  <= pwdata[15:0];
        REG_H_NW:  cfg.h_nw  <= pwdata[15:0];
        default:   cfg.mode  <= cfg.mode;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MODE:  prdata = {29'd0, cfg.mode};
      REG_ARG_X: prdata = {16'd0, cfg.arg_x};
      REG_ARG_Y: prdata = {16'd0, cfg.arg_y};
      REG_ARG_Z: prdata = {16'd0, cfg.arg_z};
      REG_H_SW:  prdata = {16'd0, cfg.h_sw};
      REG_H_SE:  prdata = {16'd0, cfg.h_se};
      REG_H_NE:  prdata = {16'd0, cfg.h_ne};
      REG_H_NW:  prdata = {16'd0, cfg.h_nw};
      default:   prdata = '0;
    endcase
  end

  vtu_pipe u_pipe (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (start && !busy),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .last_vertex (last_vertex),
    .out_valid   (done),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_z       (out_z),
    .out_last    (out_last)
  );

endmodule

[hw/rtl/vtu_pipe.sv]
// vtu_pipe: five-stage vertex arithmetic pipeline, one vertex per cycle
// depends on vtu_pkg for the config struct, mode codes and helpers
module vtu_pipe (
  input  logic               clk,
  input  logic               rst,
  input  vtu_pkg::vtu_cfg_t  cfg,
  input  logic               in_valid,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [15:0] pos_z,
  input  logic               last_vertex,
  output logic               out_valid,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic               out_last
);
  import vtu_pkg::*;

  // stage 1: capture and bias
  logic               v1, last1;
  logic signed [15:0] x1, y1, z1;
  logic signed [16:0] xo1, zo1;
  // stage 2: products
  logic               v2, last2;
  logic signed [15:0] x2, y2, z2;
  logic signed [16:0] zo2;
  logic signed [31:0] px2, py2, pz2;
  logic signed [33:0] ps2, pn2;
  // stage 3: per-mode results, edge interpolation
  logic               v3, last3;
  logic signed [31:0] x3, y3, z3;
  logic signed [16:0] zo3;
  logic signed [27:0] s3;
  logic signed [28:0] diff3;
  // stage 4: cross interpolation product
  logic               v4, last4;
  logic signed [31:0] x4, y4, z4;
  logic signed [27:0] s4;
  logic signed [45:0] prod4;

  logic signed [16:0] d_se, d_ne;
  logic signed [17:0] hsum;
  logic signed [17:0] hsum_bias;
  logic signed [15:0] avg;
  logic signed [27:0] s_next, n_next;
  logic signed [31:0] x_next, y_next, z_next;
  logic signed [31:0] ex, ez;
  logic signed [40:0] h, hill_y, y_pre;
  logic               turn_on;

  assign d_se = 17'(cfg.h_se) - 17'(cfg.h_sw);
  assign d_ne = 17'(cfg.h_ne) - 17'(cfg.h_nw);

  // truncated average of the corner heights; config is to be kept static while busy, the block does not enforce it
  assign hsum      = 18'(cfg.h_sw) + 18'(cfg.h_se) + 18'(cfg.h_ne) + 18'(cfg.h_nw);
  assign hsum_bias = hsum[17] ? 18'sd3 : 18'sd0;
  assign avg       = 16'((hsum + hsum_bias) >>> 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    x1    <= pos_x;
    y1    <= pos_y;
    z1    <= pos_z;
    last1 <= last_vertex;
    xo1   <= 17'(pos_x) + 17'sd64;
    zo1   <= 17'(pos_z) + 17'sd64;
  end

  always_ff @(posedge clk) begin
    x2    <= x1;
    y2    <= y1;
    z2    <= z1;
    zo2   <= zo1;
    last2 <= last1;
    px2   <= 32'(x1) * 32'(cfg.arg_x);
    py2   <= 32'(y1) * 32'(cfg.arg_y);
    pz2   <= 32'(z1) * 32'(cfg.arg_z);
    ps2   <= 34'(d_se) * 34'(xo1);
    pn2   <= 34'(d_ne) * 34'(xo1);
  end

  assign s_next  = 28'(cfg.h_sw) + 28'(div128(48'(ps2)));
  assign n_next  = 28'(cfg.h_nw) + 28'(div128(48'(pn2)));
  assign ex      = 32'(x2);
  assign ez      = 32'(z2);
  assign turn_on = !cfg.arg_x[15] && (cfg.arg_x != 16'sd0);

  always_comb begin
    x_next = ex;
    y_next = 32'(y2);
    z_next = ez;
    case (cfg.mode)
      MODE_TRANSLATE: begin
        x_next = ex + 32'(cfg.arg_x);
        y_next = 32'(y2) + 32'(cfg.arg_y);
        z_next = ez + 32'(cfg.arg_z);
      end
      MODE_SCALE: begin
        x_next = 32'(div128(48'(px2)));
        y_next = 32'(div128(48'(py2)));
        z_next = 32'(div128(48'(pz2)));
      end
      MODE_ORIENT: begin
        if (turn_on) begin
          case (cfg.arg_x[1:0])
            2'd1: begin
              x_next = ez;
              z_next = -ex;
            end
            2'd2: begin
              x_next = -ex;
              z_next = -ez;
            end
            2'd3: begin
              x_next = -ez;
              z_next = ex;
            end
            default: begin
              x_next = ex;
              z_next = ez;
            end
          endcase
        end
      end
      MODE_MIRROR: begin
        z_next = -ez;
      end
      default: begin
        x_next = ex;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    x3    <= x_next;
    y3    <= y_next;
    z3    <= z_next;
    zo3   <= zo2;
    last3 <= last2;
    s3    <= s_next;
    diff3 <= 29'(n_next) - 29'(s_next);
  end

  always_ff @(posedge clk) begin
    x4    <= x3;
    y4    <= y3;
    z4    <= z3;
    s4    <= s3;
    last4 <= last3;
    prod4 <= 46'(diff3) * 46'(zo3);
  end

  // ground height at the vertex, less the corner average
  assign h      = 41'(s4) + 41'(div128(48'(prod4)));
  assign hill_y = 41'(y4) + h - 41'(avg);
  assign y_pre  = (cfg.mode == MODE_HILLSKEW) ? hill_y : 41'(y4);

  always_ff @(posedge clk) begin
    out_x    <= x4;
    out_y    <= sat32(y_pre);
    out_z    <= z4;
    out_last <= last4;
  end

endmodule

[hw/rtl/vtu_checker.sv]
// vtu_checker: port-level checks on the vertex transform unit, bound to the top
// depends on vtu_pkg for port widths
module vtu_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          last_vertex,
  input logic                          done,
  input logic                          out_last,
  input logic                          pready,
  input logic [vtu_pkg::DataWidth-1:0] prdata
);
  import vtu_pkg::*;

  logic [4:0] rst_hist;
  logic       quiet5;

  // one bit per edge since the last reset, all clear once every set bit has shifted out without reset
  always_ff @(posedge clk) begin
    if (rst) begin
      rst_hist <= '1;
    end else begin
      rst_hist <= {rst_hist[3:0], 1'b0};
    end
  end

  // no reset within the span of rst_hist, so the pipeline history is intact
  assign quiet5 = (rst_hist == 5'd0);

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    quiet5 |-> (done == $past(start && !busy, 5)))
    else $error("result strobe out of step with accepted transfer");

  a_last_tracks: assert property (@(posedge clk) disable iff (rst)
    (done && quiet5) |-> (out_last == $past(last_vertex, 5)))
    else $error("out_last does not match its vertex");

  a_mode_read_narrow: assert property (@(posedge clk) disable iff (rst)
    pready && (prdata[31:16] != 16'd0) |-> 1'b0)
    else $error("register read carries bits above sixteen");

endmodule

bind vertex_transform_unit vtu_checker u_vtu_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .last_vertex (last_vertex),
  .done        (done),
  .out_last    (out_last),
  .pready      (pready),
  .prdata      (prdata)
);
